// ----- rtl/core/mcu_byte_instruction_execute_unit_macros.svh -----
// Assertion helpers for the execute unit. Clock and reset are the
// enclosing module's clk and rst_n.
`ifndef MCU_BYTE_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define MCU_BYTE_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define MBIE_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define MBIE_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- rtl/core/mbie_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mbie_pkg;
  localparam int PROGRAM_WORDS = 1024;
  localparam int STACK_DEPTH   = 8;
  localparam int BANK_SIZE     = 128;
  localparam int PC_W          = $clog2(PROGRAM_WORDS);
  localparam int SP_W          = $clog2(STACK_DEPTH);
  localparam int FA_W          = $clog2(BANK_SIZE);
  localparam int IW_W          = 14;

  // instruction groups, bits 13:12
  localparam logic [1:0] GRP_BYTE = 2'd0;
  localparam logic [1:0] GRP_BIT  = 2'd1;
  localparam logic [1:0] GRP_JUMP = 2'd2;
  localparam logic [1:0] GRP_LIT  = 2'd3;

  // byte op codes, bits 11:8
  localparam logic [3:0] OP_MISC   = 4'h0;
  localparam logic [3:0] OP_CLR    = 4'h1;
  localparam logic [3:0] OP_SUBWF  = 4'h2;
  localparam logic [3:0] OP_DECF   = 4'h3;
  localparam logic [3:0] OP_IORWF  = 4'h4;
  localparam logic [3:0] OP_ANDWF  = 4'h5;
  localparam logic [3:0] OP_XORWF  = 4'h6;
  localparam logic [3:0] OP_ADDWF  = 4'h7;
  localparam logic [3:0] OP_MOVF   = 4'h8;
  localparam logic [3:0] OP_COMF   = 4'h9;
  localparam logic [3:0] OP_INCF   = 4'ha;
  localparam logic [3:0] OP_DECFSZ = 4'hb;
  localparam logic [3:0] OP_RRF    = 4'hc;
  localparam logic [3:0] OP_RLF    = 4'hd;
  localparam logic [3:0] OP_SWAPF  = 4'he;
  localparam logic [3:0] OP_INCFSZ = 4'hf;

  // literal op codes; movlw, retlw, sublw and addlw each span a code range
  localparam logic [3:0] LOP_MOVLW_LO = 4'h0;
  localparam logic [3:0] LOP_MOVLW_HI = 4'h3;
  localparam logic [3:0] LOP_RETLW_LO = 4'h4;
  localparam logic [3:0] LOP_RETLW_HI = 4'h7;
  localparam logic [3:0] LOP_IOR      = 4'h8;
  localparam logic [3:0] LOP_AND      = 4'h9;
  localparam logic [3:0] LOP_XOR      = 4'ha;
  localparam logic [3:0] LOP_BAD      = 4'hb;
  localparam logic [3:0] LOP_SUBLW_LO = 4'hc;
  localparam logic [3:0] LOP_SUBLW_HI = 4'hd;
  localparam logic [3:0] LOP_ADDLW_LO = 4'he;
  localparam logic [3:0] LOP_ADDLW_HI = 4'hf;

  // control codes in the file field of OP_MISC
  localparam logic [6:0] F_RETURN = 7'h08;
  localparam logic [6:0] F_RETFIE = 7'h09;
  localparam logic [6:0] F_SLEEP  = 7'h63;
  localparam logic [6:0] F_CLRWDT = 7'h64;

  localparam logic [6:0] F_STATUS = 7'h03;
  localparam logic [6:0] F_PCLATH = 7'h0a;
endpackage
`default_nettype wire

// ----- rtl/core/mbie_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mbie_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] instruction_word;
  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface mbie_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] next_pc;
  logic [7:0] w_value;
  logic       carry_flag;
  logic       digit_carry_flag;
  logic       zero_flag;
  logic [7:0] file_write_address;
  logic [7:0] file_write_data;
  logic       file_written;
  logic [1:0] instr_cycles;
  logic       power_down_flag;
  logic       interrupt_enable;
  logic       unknown_opcode;
  modport source (output valid, output next_pc, output w_value, output carry_flag,
                  output digit_carry_flag, output zero_flag, output file_write_address,
                  output file_write_data, output file_written, output instr_cycles,
                  output power_down_flag, output interrupt_enable,
                  output unknown_opcode, input ready);
  modport sink   (input valid, input next_pc, input w_value, input carry_flag,
                  input digit_carry_flag, input zero_flag, input file_write_address,
                  input file_write_data, input file_written, input instr_cycles,
                  input power_down_flag, input interrupt_enable,
                  input unknown_opcode, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mbie_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mbie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/mcu_byte_instruction_execute_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "mcu_byte_instruction_execute_unit_macros.svh"
// Execute unit for an 8-bit accumulator MCU with 14-bit instruction words.
// in_ch : one instruction word per beat, taken on valid && ready.
// out_ch: one result beat per instruction: next PC, W, C/DC/Z, the file
//         write (if any), cycle count, PD, GIE and an unknown-opcode flag.
// Stages: the read stage reads both file banks at the 7-bit address as
// the beat is taken; the execute stage executes, writes back and loads
// the output register. Throughput: one instruction per cycle unless
// out_ch stalls. The read-modify-write loop on the bank RAMs is closed
// by a one-entry forward of the write made in the read cycle; W, status,
// PC and stack are flops updated at execute.
// Reset: W, PC, stack, GIE clear, TO/PD set; file valid bits clear so every
// file byte but STATUS reads zero until written. No clearing pass is needed.
// Stall: while out_ch holds an untaken beat, the execute stage holds and
// in_ch.ready drops only once the execute stage is also occupied.
module mcu_byte_instruction_execute_unit (
  input wire logic clk,
  input wire logic rst_n,
  mbie_in_if.sink    in_ch,
  mbie_out_if.source out_ch
);
  import mbie_pkg::*;

  localparam int FILE_N = 2 * BANK_SIZE;

  // pipeline control
  logic             ex_v_r;
  logic [IW_W-1:0]  ex_op_r;
  logic             ex_fire;
  logic             in_acc;
  logic             out_v_r;

  // architectural state
  logic [7:0]       w_r;
  logic             c_r, dc_r, z_r, rp0_r, to_r, pd_r, gie_r;
  logic [PC_W-1:0]  pc_r;
  logic [PC_W-1:0]  stk_r [STACK_DEPTH];
  logic [SP_W-1:0]  sp_r;
  logic [FILE_N-1:0] vld_r;
  logic [7:0]       lat0_r, lat1_r;

  // write forward from read cycle
  logic             fwd_v_r;
  logic [FA_W:0]    fwd_a_r;
  logic [7:0]       fwd_d_r;

  // RAM
  logic [7:0]       ram0_q, ram1_q;

  // execute combinational
  logic [1:0]       grp;
  logic [3:0]       sub;
  logic             dbit;
  logic [6:0]       fa;
  logic [7:0]       k8;
  logic [FA_W:0]    addr;
  logic [7:0]       r;
  logic [7:0]       res;
  logic [8:0]       sum9;
  logic             wr_en;
  logic [7:0]       wr_d;
  logic [7:0]       w_nxt;
  logic             c_nxt, dc_nxt, z_nxt, rp0_nxt, to_nxt, pd_nxt, gie_nxt;
  logic [PC_W-1:0]  pc_nxt;
  logic [SP_W-1:0]  sp_nxt;
  logic [SP_W-1:0]  sp_dec, sp_inc;
  logic             push;
  logic [1:0]       cyc;
  logic             unk;
  logic [12:0]      target;
  logic [7:0]       latch;
  logic             ex_sleep;

  assign ex_fire = ex_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !ex_v_r || ex_fire;
  assign in_acc = in_ch.valid && in_ch.ready;

  mbie_ram #(.WIDTH(8), .DEPTH(BANK_SIZE)) u_bank0 (
    .clk   (clk),
    .we    (ex_fire && wr_en && !rp0_r),
    .waddr (fa),
    .wdata (wr_d),
    .re    (in_acc),
    .raddr (in_ch.instruction_word[FA_W-1:0]),
    .rdata (ram0_q)
  );

  mbie_ram #(.WIDTH(8), .DEPTH(BANK_SIZE)) u_bank1 (
    .clk   (clk),
    .we    (ex_fire && wr_en && rp0_r),
    .waddr (fa),
    .wdata (wr_d),
    .re    (in_acc),
    .raddr (in_ch.instruction_word[FA_W-1:0]),
    .rdata (ram1_q)
  );

  assign grp  = ex_op_r[13:12];
  assign sub  = ex_op_r[11:8];
  assign dbit = ex_op_r[7];
  assign fa   = ex_op_r[6:0];
  assign k8   = ex_op_r[7:0];
  assign addr = {rp0_r, fa};
  assign sp_dec = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;
  assign sp_inc = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
  assign latch  = rp0_r ? lat1_r : lat0_r;
  // page bits land at 12:11, the PC width keeps what fits the program space
  assign target = {latch[4:3], ex_op_r[10:0]};
  assign ex_sleep = (grp == GRP_BYTE) && (sub == OP_MISC) && !dbit && (fa == F_SLEEP);

  // operand: status, forwarded write, RAM, or zero if never written
  always_comb begin
    if (fa == F_STATUS) begin
      r = {2'b00, rp0_r, to_r, pd_r, z_r, dc_r, c_r};
    end else if (fwd_v_r && fwd_a_r == addr) begin
      r = fwd_d_r;
    end else if (!vld_r[addr]) begin
      r = 8'h00;
    end else begin
      r = rp0_r ? ram1_q : ram0_q;
    end
  end

  always_comb begin
    res = 8'h00;
    sum9 = 9'd0;
    wr_en = 1'b0;
    wr_d = 8'h00;
    w_nxt = w_r;
    c_nxt = c_r; dc_nxt = dc_r; z_nxt = z_r; rp0_nxt = rp0_r;
    to_nxt = to_r; pd_nxt = pd_r; gie_nxt = gie_r;
    pc_nxt = pc_r + 1'b1;
    sp_nxt = sp_r;
    push = 1'b0;
    cyc = 2'd1;
    unk = 1'b0;
    unique case (grp)
      GRP_BYTE: begin
        if (sub == OP_MISC) begin
          if (dbit) begin
            wr_en = 1'b1; wr_d = w_r;
          end else if (fa == F_RETURN || fa == F_RETFIE) begin
            sp_nxt = sp_dec; pc_nxt = stk_r[sp_dec]; cyc = 2'd2;
            if (fa == F_RETFIE) gie_nxt = 1'b1;
          end else if (fa == F_SLEEP) begin
            pd_nxt = 1'b0; to_nxt = 1'b1;
          end else if (fa == F_CLRWDT) begin
            pd_nxt = 1'b1; to_nxt = 1'b1;
          end else if (fa[4:0] != 5'd0) begin
            unk = 1'b1;
          end
        end else if (sub == OP_CLR) begin
          if (dbit) begin
            wr_en = 1'b1; wr_d = 8'h00;
          end else begin
            w_nxt = 8'h00;
          end
        end else begin
          case (sub)
            OP_SUBWF:  begin sum9 = {1'b0, r} - {1'b0, w_r}; res = sum9[7:0]; end
            OP_ADDWF:  begin sum9 = {1'b0, r} + {1'b0, w_r}; res = sum9[7:0]; end
            OP_IORWF:  res = r | w_r;
            OP_ANDWF:  res = r & w_r;
            OP_XORWF:  res = r ^ w_r;
            OP_MOVF:   res = r;
            OP_COMF:   res = ~r;
            OP_RRF:    res = {c_r, r[7:1]};
            OP_RLF:    res = {r[6:0], c_r};
            OP_SWAPF:  res = {r[3:0], r[7:4]};
            OP_INCF, OP_INCFSZ: res = r + 8'd1;
            default:   res = r - 8'd1;
          endcase
          if (dbit) begin
            wr_en = 1'b1; wr_d = res;
          end else begin
            w_nxt = res;
          end
          if ((sub == OP_DECFSZ || sub == OP_INCFSZ) && res == 8'h00) begin
            pc_nxt = pc_r + PC_W'(2); cyc = 2'd2;
          end
        end
      end
      GRP_BIT: unk = 1'b1;
      GRP_JUMP: begin
        if (!ex_op_r[11]) begin
          push = 1'b1; sp_nxt = sp_inc;
        end
        pc_nxt = target[PC_W-1:0]; cyc = 2'd2;
      end
      default: begin
        case (sub) inside
          [LOP_MOVLW_LO:LOP_MOVLW_HI]: w_nxt = k8;
          [LOP_RETLW_LO:LOP_RETLW_HI]: begin
            w_nxt = k8; sp_nxt = sp_dec; pc_nxt = stk_r[sp_dec]; cyc = 2'd2;
          end
          LOP_IOR: w_nxt = w_r | k8;
          LOP_AND: w_nxt = w_r & k8;
          LOP_XOR: w_nxt = w_r ^ k8;
          LOP_BAD: unk = 1'b1;
          [LOP_SUBLW_LO:LOP_SUBLW_HI]: begin
            sum9 = {1'b0, k8} - {1'b0, w_r}; w_nxt = sum9[7:0];
          end
          default: begin
            sum9 = {1'b0, k8} + {1'b0, w_r}; w_nxt = sum9[7:0];
          end
        endcase
      end
    endcase

    // status write lands first, instruction flags after
    if (wr_en && fa == F_STATUS) begin
      c_nxt = wr_d[0]; dc_nxt = wr_d[1]; z_nxt = wr_d[2]; rp0_nxt = wr_d[5];
    end
    if (grp == GRP_BYTE) begin
      if (sub == OP_CLR) begin
        z_nxt = 1'b1;
      end else if (sub == OP_SUBWF) begin
        z_nxt = (res == 8'h00); c_nxt = (r >= w_r); dc_nxt = (r[3:0] >= w_r[3:0]);
      end else if (sub == OP_ADDWF) begin
        z_nxt = (res == 8'h00); c_nxt = sum9[8];
        dc_nxt = ({1'b0, r[3:0]} + {1'b0, w_r[3:0]}) > 5'd15;
      end else if (sub == OP_RRF) begin
        c_nxt = r[0];
      end else if (sub == OP_RLF) begin
        c_nxt = r[7];
      end else if (sub == OP_DECF || sub == OP_IORWF || sub == OP_ANDWF ||
                   sub == OP_XORWF || sub == OP_MOVF || sub == OP_COMF ||
                   sub == OP_INCF) begin
        z_nxt = (res == 8'h00);
      end
    end else if (grp == GRP_LIT) begin
      if (sub == LOP_IOR || sub == LOP_AND || sub == LOP_XOR) begin
        z_nxt = (w_nxt == 8'h00);
      end else if (sub == LOP_SUBLW_LO || sub == LOP_SUBLW_HI) begin
        z_nxt = (w_nxt == 8'h00); c_nxt = (k8 >= w_r); dc_nxt = (k8[3:0] >= w_r[3:0]);
      end else if (sub == LOP_ADDLW_LO || sub == LOP_ADDLW_HI) begin
        z_nxt = (w_nxt == 8'h00); c_nxt = sum9[8];
        dc_nxt = ({1'b0, k8[3:0]} + {1'b0, w_r[3:0]}) > 5'd15;
      end
    end
  end

  // pipeline and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r <= 1'b0; out_v_r <= 1'b0; fwd_v_r <= 1'b0;
      w_r <= 8'h00; c_r <= 1'b0; dc_r <= 1'b0; z_r <= 1'b0; rp0_r <= 1'b0;
      to_r <= 1'b1; pd_r <= 1'b1; gie_r <= 1'b0;
      pc_r <= '0; sp_r <= '0; vld_r <= '0;
      lat0_r <= 8'h00; lat1_r <= 8'h00;
      for (int i = 0; i < STACK_DEPTH; i++) stk_r[i] <= '0;
    end else begin
      if (in_acc) begin
        ex_v_r <= 1'b1;
        // capture this cycle's write for the instruction now reading
        fwd_v_r <= ex_fire && wr_en;
      end else if (ex_fire) begin
        ex_v_r <= 1'b0;
      end
      if (ex_fire) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (ex_fire) begin
        w_r <= w_nxt; c_r <= c_nxt; dc_r <= dc_nxt; z_r <= z_nxt; rp0_r <= rp0_nxt;
        to_r <= to_nxt; pd_r <= pd_nxt; gie_r <= gie_nxt;
        pc_r <= pc_nxt; sp_r <= sp_nxt;
        if (push) stk_r[sp_r] <= pc_r + 1'b1;
        if (wr_en) begin
          vld_r[addr] <= 1'b1;
          if (fa == F_PCLATH) begin
            if (rp0_r) lat1_r <= wr_d;
            else lat0_r <= wr_d;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_op_r <= in_ch.instruction_word;
      fwd_a_r <= addr;
      fwd_d_r <= wr_d;
    end
    if (ex_fire) begin
      out_ch.next_pc            <= pc_nxt;
      out_ch.w_value            <= w_nxt;
      out_ch.carry_flag         <= c_nxt;
      out_ch.digit_carry_flag   <= dc_nxt;
      out_ch.zero_flag          <= z_nxt;
      out_ch.file_write_address <= wr_en ? addr : 8'h00;
      out_ch.file_write_data    <= wr_en ? wr_d : 8'h00;
      out_ch.file_written       <= wr_en;
      out_ch.instr_cycles       <= cyc;
      out_ch.power_down_flag    <= pd_nxt;
      out_ch.interrupt_enable   <= gie_nxt;
      out_ch.unknown_opcode     <= unk;
    end
  end

  assign out_ch.valid = out_v_r;

  `MBIE_ASSERT_NOW(a_stall_blocks_in, ex_v_r && !ex_fire, !in_ch.ready, "input taken in stall")
  `MBIE_ASSERT_NOW(a_unknown_no_write, ex_fire && unk, !wr_en, "unknown opcode wrote file")
  `MBIE_ASSERT_NEXT(a_sleep_clears_pd, ex_fire && ex_sleep, !pd_r && to_r, "sleep left PD set")
endmodule
`default_nettype wire
